@@ design/ewdm_pkg.sv @@
// ----------------------------------------------------------------------------
// Encoder wrap delta median package
// Field widths and default parameter values shared by the encoder delta
// median block.
// ----------------------------------------------------------------------------
package ewdm_pkg;

   localparam int POSITION_W = 14;
   localparam int CHANGE_W   = 15;
   localparam int MEDIAN_W   = 16;

   localparam int WINDOW_SIZE_DEFAULT  = 5;
   localparam int POSITION_MAX_DEFAULT = 16383;

endpackage

@@ design/encoder_wrap_delta_median_core.sv @@
// ----------------------------------------------------------------------------
// Encoder wrap delta median core
// Forms the wrap-corrected change between successive absolute encoder
// readings and reports it with twice the median of the last few changes.
// ----------------------------------------------------------------------------
// Each word on the req_ channel carries one absolute encoder reading. Each
// accepted word gives exactly one word on the rsp_ channel, with the signed
// change since the previous reading and twice the median of the held changes.
// A word moves when valid is high and stall is low.
// The block has two register stages: the change is formed and registered in
// the cycle a reading is accepted, and the windowed median is then formed
// from the change register into the output register, which raises rsp_valid.
// While rsp_stall is low, one word is accepted in every cycle. The rate is
// set by the single-pass rank and select network over the window registers.
// When rsp_stall is high, the output word holds and the change stage refills;
// req_stall rises only once both stages hold words.
// Reset clears the previous reading to zero, empties the window and clears
// both stages. The window entries themselves are not reset; only entries
// already written are ever ranked.
// ----------------------------------------------------------------------------
module encoder_wrap_delta_median_core #(
   parameter int WINDOW_SIZE  = ewdm_pkg::WINDOW_SIZE_DEFAULT,
   parameter int POSITION_MAX = ewdm_pkg::POSITION_MAX_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic        [ewdm_pkg::POSITION_W-1:0] req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [ewdm_pkg::CHANGE_W-1:0]   rsp_raw_change,
   output logic signed [ewdm_pkg::MEDIAN_W-1:0]   rsp_median_change_x2
);

   localparam int POS_W  = ewdm_pkg::POSITION_W;
   localparam int CHG_W  = ewdm_pkg::CHANGE_W;
   localparam int MED_W  = ewdm_pkg::MEDIAN_W;
   localparam int SPAN_W = $clog2(POSITION_MAX + 2);
   localparam int DIFF_W = ((SPAN_W > POS_W) ? SPAN_W : POS_W) + 2;
   localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
   localparam int CHG_MAX = 2 ** (CHG_W - 1) - 1;
   localparam int CHG_MIN = -CHG_MAX - 1;

   localparam logic signed [DIFF_W-1:0] HALF_D    = DIFF_W'(POSITION_MAX / 2);
   localparam logic signed [DIFF_W-1:0] SPAN_D    = DIFF_W'(POSITION_MAX + 1);
   localparam logic signed [DIFF_W-1:0] CHG_MAX_D = DIFF_W'(CHG_MAX);
   localparam logic signed [DIFF_W-1:0] CHG_MIN_D = DIFF_W'(CHG_MIN);
   localparam logic [SLOT_W-1:0]        SLOT_LAST = SLOT_W'(WINDOW_SIZE - 1);
   localparam logic [FILL_W-1:0]        FILL_FULL = FILL_W'(WINDOW_SIZE);

   logic        [POS_W-1:0]  last_position_ff;
   logic                     chg_valid_ff;
   logic signed [CHG_W-1:0]  chg_ff;
   logic signed [CHG_W-1:0]  chg_in;
   logic signed [CHG_W-1:0]  window_ff [WINDOW_SIZE];
   logic        [FILL_W-1:0] fill_ff;
   logic        [FILL_W-1:0] fill_in;
   logic        [SLOT_W-1:0] slot_ff;
   logic        [SLOT_W-1:0] slot_in;
   logic                     rsp_valid_ff;
   logic signed [CHG_W-1:0]  rsp_raw_change_ff;
   logic signed [MED_W-1:0]  rsp_median_ff;
   logic signed [MED_W-1:0]  median_in;

   logic advance;
   logic req_accept;

   assign advance    = chg_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = chg_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   // Wrap-corrected change from the previous reading, saturated to the field.
   always_comb begin
      logic signed [DIFF_W-1:0] cur_s;
      logic signed [DIFF_W-1:0] prev_s;
      logic signed [DIFF_W-1:0] diff;
      logic signed [DIFF_W-1:0] mag;
      cur_s  = signed'(DIFF_W'(req_position));
      prev_s = signed'(DIFF_W'(last_position_ff));
      diff   = cur_s - prev_s;
      mag    = (diff < 0) ? -diff : diff;
      if (mag > HALF_D) begin
         if (diff >= 0) begin
            diff = diff - SPAN_D;
         end else begin
            diff = diff + SPAN_D;
         end
      end
      if (diff < CHG_MIN_D) begin
         diff = CHG_MIN_D;
      end else if (diff > CHG_MAX_D) begin
         diff = CHG_MAX_D;
      end
      chg_in = diff[CHG_W-1:0];
   end

   assign fill_in = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + 1'b1;
   assign slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;

   // Median of the window as it stands once the pending change is written.
   // Each held entry is ranked against all others, ties broken by index, and
   // the two middle ranks are selected and summed.
   always_comb begin
      logic signed [CHG_W-1:0]  view [WINDOW_SIZE];
      logic        [WINDOW_SIZE-1:0] held;
      logic        [WINDOW_SIZE-1:0] below;
      logic        [FILL_W-1:0] rank;
      logic        [FILL_W-1:0] k_lo;
      logic        [FILL_W-1:0] k_hi;
      logic        [CHG_W-1:0]  lo_val;
      logic        [CHG_W-1:0]  hi_val;
      k_lo   = (fill_in - 1'b1) >> 1;
      k_hi   = fill_in >> 1;
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         view[i] = (SLOT_W'(i) == slot_ff) ? chg_ff : window_ff[i];
         held[i] = FILL_W'(i) < fill_in;
      end
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         for (int j = 0; j < WINDOW_SIZE; j++) begin
            below[j] = held[j] && (!held[i] || (view[j] < view[i]) ||
                                   ((view[j] == view[i]) && (j < i)));
         end
         rank = FILL_W'($countones(below));
         if (held[i] && (rank == k_lo)) begin
            lo_val = lo_val | view[i];
         end
         if (held[i] && (rank == k_hi)) begin
            hi_val = hi_val | view[i];
         end
      end
      median_in = MED_W'(signed'(lo_val)) + MED_W'(signed'(hi_val));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_position_ff <= '0;
         chg_valid_ff     <= 1'b0;
         fill_ff          <= '0;
         slot_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (req_accept) begin
            last_position_ff <= req_position;
            chg_valid_ff     <= 1'b1;
         end else if (advance) begin
            chg_valid_ff <= 1'b0;
         end
         if (advance) begin
            fill_ff      <= fill_in;
            slot_ff      <= slot_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         chg_ff <= chg_in;
      end
      if (advance) begin
         window_ff[slot_ff] <= chg_ff;
         rsp_raw_change_ff  <= chg_ff;
         rsp_median_ff      <= median_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_raw_change       = rsp_raw_change_ff;
   assign rsp_median_change_x2 = rsp_median_ff;

endmodule
